// ===== rtl/core/fwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// fwsm_pkg
// Shared constants, codes and types of the weighted window filter.
// ----------------------------------------------------------------------------
package fwsm_pkg;

   // window and line store geometry
   localparam int MAX_WINDOW  = 7;
   localparam int MAX_LINE    = 2048;
   localparam int LINES       = MAX_WINDOW + 1;
   localparam int LINE_AW     = $clog2(MAX_LINE);
   localparam int LINE_RW     = $clog2(LINES);
   localparam int STORE_DEPTH = LINES * MAX_LINE;
   localparam int STORE_AW    = LINE_RW + LINE_AW;
   localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
   localparam int CNT_W       = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

   // field widths
   localparam int PIX_W  = 16;
   localparam int ACC_W  = 40;
   localparam int ROW_W  = 16;
   localparam int COLR_W = 12;
   localparam int STEP_W = $clog2(ACC_W + 1);

   // results per input word
   localparam int BURST   = 4;
   localparam int BURST_W = $clog2(BURST + 1);

   localparam logic [WIN_W-1:0] HALF_CAP = WIN_W'((MAX_WINDOW - 1) / 2);

   // input opcodes
   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_PIXEL  = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_WIN_ROWS  = 3'd0;
   localparam logic [2:0] REG_WIN_COLS  = 3'd1;
   localparam logic [2:0] REG_RAST_ROWS = 3'd2;
   localparam logic [2:0] REG_RAST_COLS = 3'd3;
   localparam logic [2:0] REG_MEAN      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_WAIT,
      ST_DIV,
      ST_PUT
   } state_type;

   // one pixel handed to every cell of the chain
   typedef struct packed {
      logic                    valid;
      logic                    first;
      logic [WIN_W-1:0]        row;
      logic signed [PIX_W-1:0] pixel;
   } feed_type;

   // weight load into one cell
   typedef struct packed {
      logic                    we;
      logic [WIN_W-1:0]        row;
      logic signed [PIX_W-1:0] value;
   } wload_type;

   // half window size, even sizes act as the next lower odd size
   function automatic logic [WIN_W-1:0] half_of(input logic [2:0] w);
      logic [WIN_W-1:0] h;
      h = (w == 3'd0) ? '0 : WIN_W'((w - 3'd1) >> 1);
      if (h > HALF_CAP) h = HALF_CAP;
      return h;
   endfunction

endpackage

// ===== rtl/core/fwsm_ram.sv =====
// ----------------------------------------------------------------------------
// fwsm_ram
// Generic simple dual port RAM with registered read.
// ----------------------------------------------------------------------------
module fwsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fwsm_cell.sv =====
// ----------------------------------------------------------------------------
// fwsm_cell
// One tap of the transposed multiply-add chain; holds one weight column.
// ----------------------------------------------------------------------------
module fwsm_cell (
   input  logic                              clock,
   input  fwsm_pkg::wload_type               wload,
   input  fwsm_pkg::feed_type                feed,
   input  logic                              active,
   input  logic signed [fwsm_pkg::ACC_W-1:0] sum_in,
   output logic signed [fwsm_pkg::ACC_W-1:0] sum_out
);

   logic signed [fwsm_pkg::PIX_W-1:0]   weight_ff [fwsm_pkg::MAX_WINDOW];
   logic signed [2*fwsm_pkg::PIX_W-1:0] prod;
   logic signed [fwsm_pkg::ACC_W-1:0]   base;
   logic signed [fwsm_pkg::ACC_W-1:0]   sum_in_w;
   logic signed [fwsm_pkg::ACC_W-1:0]   sum_ff;

   // weight column store
   always_ff @(posedge clock) begin
      if (wload.we) begin
         weight_ff[wload.row] <= wload.value;
      end
   end

   // product of the broadcast pixel and this tap's weight
   assign prod     = feed.pixel * weight_ff[feed.row];
   assign base     = feed.first ? '0 : sum_in;
   assign sum_in_w = active ? (base + fwsm_pkg::ACC_W'(prod)) : base;

   // partial sum moves one cell toward the head with each valid feed pixel
   always_ff @(posedge clock) begin
      if (feed.valid) begin
         sum_ff <= sum_in_w;
      end
   end

   assign sum_out = sum_ff;

endmodule

// ===== rtl/core/fwsm_div.sv =====
// ----------------------------------------------------------------------------
// fwsm_div
// Bit-serial signed by unsigned divider, truncates toward zero.
// ----------------------------------------------------------------------------
module fwsm_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [fwsm_pkg::ACC_W-1:0] dividend,
   input  logic [fwsm_pkg::CNT_W-1:0]        divisor,
   output logic                              done,
   output logic signed [fwsm_pkg::ACC_W-1:0] quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [fwsm_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                             neg_ff, neg_in;
   logic [fwsm_pkg::ACC_W-1:0]       quo_ff, quo_in;
   logic [fwsm_pkg::CNT_W-1:0]       rem_ff, rem_in;
   logic [fwsm_pkg::CNT_W-1:0]       dvs_ff, dvs_in;
   logic [fwsm_pkg::CNT_W:0]         rem_sh;
   logic                             ge;

   // one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[fwsm_pkg::ACC_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[fwsm_pkg::ACC_W-1];
         quo_in  = dividend[fwsm_pkg::ACC_W-1] ? -dividend : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? fwsm_pkg::CNT_W'(rem_sh - {1'b0, dvs_ff})
                      : rem_sh[fwsm_pkg::CNT_W-1:0];
         quo_in  = {quo_ff[fwsm_pkg::ACC_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == fwsm_pkg::STEP_W'(fwsm_pkg::ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ===== rtl/core/focal_weighted_sum_mean_filter.sv =====
// ----------------------------------------------------------------------------
// focal_weighted_sum_mean_filter
// Streaming weighted window filter: line store, chain of multiply-add taps,
// serial divider for mean mode.
// ----------------------------------------------------------------------------
// Each result is computed by the line store read port feeding one pixel per cycle
// of its window into the tap chain; mean mode adds a pass through the serial
// divider per result. A new word is accepted only after all results of the last
// one (up to 4, none for weight loads and ignored words) have gone to the output
// register; rsp stalls hold the block. Reset clears positions and handshakes and
// sets the registers to their defaults; store and weights undefined.
// ----------------------------------------------------------------------------
module focal_weighted_sum_mean_filter (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // weight_row, weight_col, weight_value, pixel
   input  logic [1:0]  req_tuser,   // opcode
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // result, out_row, out_col
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // frame_done
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int ROWX_W = fwsm_pkg::ROW_W + 1;
   localparam int LA     = fwsm_pkg::LINE_AW;
   localparam int WW     = fwsm_pkg::WIN_W;

   fwsm_pkg::state_type state_ff, state_in;

   logic [2:0]                       win_rows_ff, win_rows_in;
   logic [2:0]                       win_cols_ff, win_cols_in;
   logic [fwsm_pkg::ROW_W-1:0]       rast_rows_ff, rast_rows_in;
   logic [fwsm_pkg::COLR_W-1:0]      rast_cols_ff, rast_cols_in;
   logic                             mean_ff, mean_in;

   logic [ROWX_W-1:0]                in_row_ff, in_row_in;
   logic [LA-1:0]                    in_col_ff, in_col_in;
   logic [fwsm_pkg::ROW_W-1:0]       emit_row_ff, emit_row_in;
   logic [LA-1:0]                    emit_col_ff, emit_col_in;
   logic                             open_ff, open_in;
   logic [fwsm_pkg::BURST_W-1:0]     n_ff, n_in;
   logic [WW-1:0]                    i_ff, i_in;
   logic [WW-1:0]                    j_ff, j_in;
   logic signed [fwsm_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [fwsm_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic signed [fwsm_pkg::ACC_W-1:0] res_ff, res_in;

   logic                             b_valid_ff, b_first_ff, b_last_ff, b_final_ff;
   logic                             b_inimg_ff;
   logic [WW-1:0]                    b_row_ff;
   logic                             c_last_ff, c_final_ff;

   logic                             out_valid_ff, out_valid_in;
   logic signed [fwsm_pkg::ACC_W-1:0] out_result_ff, out_result_in;
   logic [fwsm_pkg::ROW_W-1:0]       out_row_ff, out_row_in;
   logic [LA-1:0]                    out_col_ff, out_col_in;
   logic                             out_last_ff, out_last_in;
   logic                             out_done_ff, out_done_in;

   // effective configuration
   logic [fwsm_pkg::ROW_W-1:0]       rows_eff;
   logic [fwsm_pkg::COLR_W-1:0]      cols_eff;
   logic [LA-1:0]                    col_max;
   logic [WW-1:0]                    hr, hc, wlen_m1, rlen_m1;

   // decoded input word
   logic                             req_acc;
   logic [1:0]                       opcode;
   logic [2:0]                       w_row, w_col;
   logic signed [fwsm_pkg::PIX_W-1:0] w_value, pixel;

   // issue stage
   logic [17:0]                      rr;
   logic [12:0]                      cc;
   logic                             iss_inimg, iss_first, iss_last, iss_final, iss_run;
   logic [fwsm_pkg::STORE_AW-1:0]    rd_addr;
   logic [fwsm_pkg::PIX_W-1:0]       rd_data;
   logic                             st_we;
   logic [fwsm_pkg::STORE_AW-1:0]    st_addr;

   // chain
   fwsm_pkg::feed_type               feed;
   fwsm_pkg::wload_type              wload [fwsm_pkg::MAX_WINDOW];
   logic signed [fwsm_pkg::ACC_W-1:0] sums [fwsm_pkg::MAX_WINDOW+1];
   logic signed [fwsm_pkg::ACC_W-1:0] total;

   // divider
   logic                             div_start, div_done;
   logic signed [fwsm_pkg::ACC_W-1:0] div_q;

   // emit bookkeeping
   logic                             rdy_now, rdy_next, done_now, more, out_free;
   logic [fwsm_pkg::ROW_W-1:0]       nx_row;
   logic [LA-1:0]                    nx_col;

   function automatic logic win_ready(
      input logic [fwsm_pkg::ROW_W-1:0] er,
      input logic [LA-1:0]              ec,
      input logic [WW-1:0]              hrv,
      input logic [WW-1:0]              hcv,
      input logic [LA-1:0]              cm,
      input logic [ROWX_W-1:0]          inr,
      input logic [LA-1:0]              inc
   );
      logic [ROWX_W-1:0] trow;
      logic [LA:0]       tc;
      logic [LA-1:0]     tcol;
      trow = {1'b0, er} + ROWX_W'(hrv);
      tc   = {1'b0, ec} + (LA+1)'(hcv);
      tcol = (tc > {1'b0, cm}) ? cm : tc[LA-1:0];
      return !((trow > inr) || ((trow == inr) && (tcol > inc)));
   endfunction

   // input word fields
   assign req_acc = req_tvalid && req_tready;
   assign opcode  = req_tuser;
   assign w_row   = req_tdata[2:0];
   assign w_col   = req_tdata[5:3];
   assign w_value = $signed(req_tdata[21:6]);
   assign pixel   = $signed(req_tdata[37:22]);

   // effective sizes
   always_comb begin
      rows_eff = (rast_rows_ff == '0) ? fwsm_pkg::ROW_W'(1) : rast_rows_ff;
      if (rast_cols_ff == '0) begin
         cols_eff = fwsm_pkg::COLR_W'(1);
      end else if (rast_cols_ff > fwsm_pkg::COLR_W'(fwsm_pkg::MAX_LINE)) begin
         cols_eff = fwsm_pkg::COLR_W'(fwsm_pkg::MAX_LINE);
      end else begin
         cols_eff = rast_cols_ff;
      end
      col_max = LA'(cols_eff - 1'b1);
      hr      = fwsm_pkg::half_of(win_rows_ff);
      hc      = fwsm_pkg::half_of(win_cols_ff);
      wlen_m1 = WW'({hc, 1'b0});
      rlen_m1 = WW'({hr, 1'b0});
   end

   // window cell address for the current issue step
   always_comb begin
      rr        = 18'(emit_row_ff) - 18'(hr) + 18'(i_ff);
      cc        = 13'(emit_col_ff) - 13'(hc) + 13'(j_ff);
      iss_inimg = !rr[17] && (rr[16:0] < {1'b0, rows_eff}) &&
                  !cc[12] && (cc[11:0] < cols_eff);
      iss_run   = (state_ff == fwsm_pkg::ST_RUN);
      iss_first = (j_ff == wlen_m1);
      iss_last  = (j_ff == '0);
      iss_final = iss_last && (i_ff == rlen_m1);
      rd_addr   = {rr[fwsm_pkg::LINE_RW-1:0], cc[LA-1:0]};
   end

   // pixel write into the line store
   assign st_we   = req_acc && (opcode != fwsm_pkg::OP_WEIGHT) &&
                    (opcode != fwsm_pkg::OP_NONE) &&
                    ((opcode == fwsm_pkg::OP_PIXEL) || open_ff) &&
                    (in_row_ff < {1'b0, rows_eff}) && ({1'b0, in_col_ff} < cols_eff);
   assign st_addr = {in_row_ff[fwsm_pkg::LINE_RW-1:0], in_col_ff};

   fwsm_ram #(
      .WIDTH (fwsm_pkg::PIX_W),
      .DEPTH (fwsm_pkg::STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_addr),
      .wr_data ((opcode == fwsm_pkg::OP_PIXEL) ? pixel : '0),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read stage flags, aligned with the store read data
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_last_ff  <= 1'b0;
         c_final_ff <= 1'b0;
      end else begin
         b_valid_ff <= iss_run;
         c_last_ff  <= b_valid_ff && b_last_ff;
         c_final_ff <= b_valid_ff && b_final_ff;
      end
      b_first_ff <= iss_first;
      b_last_ff  <= iss_last;
      b_final_ff <= iss_final;
      b_inimg_ff <= iss_inimg;
      b_row_ff   <= i_ff;
   end

   assign feed.valid = b_valid_ff;
   assign feed.first = b_first_ff;
   assign feed.row   = b_row_ff;
   assign feed.pixel = b_inimg_ff ? $signed(rd_data) : '0;

   // tap chain, partial sums flow toward cell zero
   assign sums[fwsm_pkg::MAX_WINDOW] = '0;

   for (genvar k = 0; k < fwsm_pkg::MAX_WINDOW; k++) begin : g_cell
      assign wload[k].we    = req_acc && (opcode == fwsm_pkg::OP_WEIGHT) &&
                              (WW'(w_row) < WW'(fwsm_pkg::MAX_WINDOW)) &&
                              (WW'(w_col) == WW'(k));
      assign wload[k].row   = WW'(w_row);
      assign wload[k].value = w_value;

      fwsm_cell u_cell (
         .clock   (clock),
         .wload   (wload[k]),
         .feed    (feed),
         .active  (WW'(k) <= wlen_m1),
         .sum_in  (sums[k+1]),
         .sum_out (sums[k])
      );
   end

   assign total = acc_ff + sums[0];

   fwsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // next emit position and release checks
   always_comb begin
      done_now = (emit_row_ff == rows_eff - 1'b1) && (emit_col_ff == col_max);
      if (emit_col_ff == col_max) begin
         nx_col = '0;
         nx_row = emit_row_ff + 1'b1;
      end else begin
         nx_col = emit_col_ff + 1'b1;
         nx_row = emit_row_ff;
      end
      rdy_now  = win_ready(emit_row_ff, emit_col_ff, hr, hc, col_max,
                           in_row_ff, in_col_ff);
      rdy_next = win_ready(nx_row, nx_col, hr, hc, col_max, in_row_ff, in_col_ff);
      more     = !done_now && ((n_ff + 1'b1) < fwsm_pkg::BURST_W'(fwsm_pkg::BURST)) &&
                 rdy_next;
      out_free = !out_valid_ff || rsp_tready;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      win_rows_in   = win_rows_ff;
      win_cols_in   = win_cols_ff;
      rast_rows_in  = rast_rows_ff;
      rast_cols_in  = rast_cols_ff;
      mean_in       = mean_ff;
      in_row_in     = in_row_ff;
      in_col_in     = in_col_ff;
      emit_row_in   = emit_row_ff;
      emit_col_in   = emit_col_ff;
      open_in       = open_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      div_start     = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_result_in = out_result_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;

      // count in-image cells and gather row sums
      if (b_valid_ff && b_inimg_ff) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (c_last_ff) begin
         acc_in = total;
      end

      case (state_ff)
         fwsm_pkg::ST_IDLE: begin
            if (req_acc) begin
               if ((opcode == fwsm_pkg::OP_PIXEL) ||
                   ((opcode == fwsm_pkg::OP_FLUSH) && open_ff)) begin
                  open_in  = 1'b1;
                  n_in     = '0;
                  state_in = fwsm_pkg::ST_CHECK;
               end
            end
         end
         fwsm_pkg::ST_CHECK: begin
            if (rdy_now) begin
               i_in     = '0;
               j_in     = wlen_m1;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = fwsm_pkg::ST_RUN;
            end else begin
               if (in_col_ff == col_max) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + 1'b1;
               end else begin
                  in_col_in = in_col_ff + 1'b1;
               end
               state_in = fwsm_pkg::ST_IDLE;
            end
         end
         fwsm_pkg::ST_RUN: begin
            if (iss_last) begin
               j_in = wlen_m1;
               if (iss_final) begin
                  state_in = fwsm_pkg::ST_WAIT;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff - 1'b1;
            end
         end
         fwsm_pkg::ST_WAIT: begin
            if (c_last_ff && c_final_ff) begin
               if (mean_ff) begin
                  div_start = 1'b1;
                  state_in  = fwsm_pkg::ST_DIV;
               end else begin
                  res_in   = total;
                  state_in = fwsm_pkg::ST_PUT;
               end
            end
         end
         fwsm_pkg::ST_DIV: begin
            if (div_done) begin
               res_in   = div_q;
               state_in = fwsm_pkg::ST_PUT;
            end
         end
         fwsm_pkg::ST_PUT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_result_in = res_ff;
               out_row_in    = emit_row_ff;
               out_col_in    = emit_col_ff;
               out_last_in   = !more;
               out_done_in   = done_now;
               n_in          = n_ff + 1'b1;
               if (done_now) begin
                  in_row_in   = '0;
                  in_col_in   = '0;
                  emit_row_in = '0;
                  emit_col_in = '0;
                  open_in     = 1'b0;
                  state_in    = fwsm_pkg::ST_IDLE;
               end else begin
                  emit_row_in = nx_row;
                  emit_col_in = nx_col;
                  if (more) begin
                     i_in     = '0;
                     j_in     = wlen_m1;
                     acc_in   = '0;
                     cnt_in   = '0;
                     state_in = fwsm_pkg::ST_RUN;
                  end else begin
                     if (in_col_ff == col_max) begin
                        in_col_in = '0;
                        in_row_in = in_row_ff + 1'b1;
                     end else begin
                        in_col_in = in_col_ff + 1'b1;
                     end
                     state_in = fwsm_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = fwsm_pkg::ST_IDLE;
         end
      endcase

      // register writes restart the frame
      if (csr_valid) begin
         case (csr_index)
            fwsm_pkg::REG_WIN_ROWS:  win_rows_in  = csr_data[2:0];
            fwsm_pkg::REG_WIN_COLS:  win_cols_in  = csr_data[2:0];
            fwsm_pkg::REG_RAST_ROWS: rast_rows_in = csr_data;
            fwsm_pkg::REG_RAST_COLS: rast_cols_in = csr_data[fwsm_pkg::COLR_W-1:0];
            fwsm_pkg::REG_MEAN:      mean_in      = csr_data[0];
            default: ;
         endcase
         if (csr_index <= fwsm_pkg::REG_MEAN) begin
            in_row_in   = '0;
            in_col_in   = '0;
            emit_row_in = '0;
            emit_col_in = '0;
            open_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwsm_pkg::ST_IDLE;
         win_rows_ff  <= 3'd3;
         win_cols_ff  <= 3'd3;
         rast_rows_ff <= fwsm_pkg::ROW_W'(1);
         rast_cols_ff <= fwsm_pkg::COLR_W'(1);
         mean_ff      <= 1'b0;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         emit_row_ff  <= '0;
         emit_col_ff  <= '0;
         open_ff      <= 1'b0;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_rows_ff  <= win_rows_in;
         win_cols_ff  <= win_cols_in;
         rast_rows_ff <= rast_rows_in;
         rast_cols_ff <= rast_cols_in;
         mean_ff      <= mean_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         emit_row_ff  <= emit_row_in;
         emit_col_ff  <= emit_col_in;
         open_ff      <= open_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         out_valid_ff <= out_valid_in;
      end
      acc_ff        <= acc_in;
      cnt_ff        <= cnt_in;
      res_ff        <= res_in;
      out_result_ff <= out_result_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   // ports
   assign req_tready = (state_ff == fwsm_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_col_ff, out_row_ff, out_result_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the weighted window filter. A predictor follows
// every accepted input word and queues the filtered pixels it should release.
// A checker compares each result word, field by field, with the oldest
// queued one. Directed tests cover weight loads, ignored words, frame
// extremes and odd, even and zero window sizes. A random phase then runs small frames.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [39:0] value;
      logic [15:0] row;
      logic [10:0] col;
      logic        last;
      logic        done;
   } filtered_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;    // weight_row, weight_col, weight_value, pixel
   logic [1:0]  req_tuser = fwsm_pkg::OP_NONE;  // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // result, out_row, out_col
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;         // frame_done
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = fwsm_pkg::REG_WIN_ROWS;
   logic [15:0] csr_data = '0;

   focal_weighted_sum_mean_filter u_top (.*);

   always #1 clock = ~clock;

   // predictor state
   shortint        pixel_lines [fwsm_pkg::LINES*fwsm_pkg::MAX_LINE];
   shortint        weights [fwsm_pkg::MAX_WINDOW*fwsm_pkg::MAX_WINDOW];
   int unsigned    in_row, in_col, emit_row, emit_col;
   bit             frame_open;
   int unsigned    win_rows_cfg, win_cols_cfg, rast_rows_cfg, rast_cols_cfg, mean_cfg;
   filtered_pixel_type filtered_q[$];

   int send_gap_pct = 32;
   int stall_pct    = 47;
   int mismatches   = 0;
   int checked      = 0;
   int pixels_sent  = 0;
   int frames_done  = 0;
   int idle_cycles  = 0;

   function automatic int unsigned half_size(int unsigned w);
      int unsigned h;
      h = (w >= 1) ? (w - 1) / 2 : 0;
      return (h > (fwsm_pkg::MAX_WINDOW - 1) / 2) ? (fwsm_pkg::MAX_WINDOW - 1) / 2 : h;
   endfunction

   function automatic int unsigned frame_rows();
      return (rast_rows_cfg == 0) ? 1 : rast_rows_cfg;
   endfunction

   function automatic int unsigned frame_cols();
      if (rast_cols_cfg == 0) return 1;
      return (rast_cols_cfg > fwsm_pkg::MAX_LINE) ? fwsm_pkg::MAX_LINE : rast_cols_cfg;
   endfunction

   // weighted sum (or mean) over the in-image cells around (er,ec)
   function automatic longint window_sum(int unsigned er, int unsigned ec);
      longint acc, cnt, rr, cc;
      int unsigned hr, hc;
      acc = 0;
      cnt = 0;
      hr = half_size(win_rows_cfg);
      hc = half_size(win_cols_cfg);
      for (int i = 0; i <= 2*hr; i++) begin
         rr = longint'(er) - hr + i;
         if (rr < 0 || rr >= frame_rows()) continue;
         for (int j = 0; j <= 2*hc; j++) begin
            cc = longint'(ec) - hc + j;
            if (cc < 0 || cc >= frame_cols()) continue;
            acc += longint'(pixel_lines[(rr % fwsm_pkg::LINES)*fwsm_pkg::MAX_LINE + cc]) *
                   longint'(weights[i*fwsm_pkg::MAX_WINDOW + j]);
            cnt++;
         end
      end
      if (mean_cfg != 0 && cnt > 0) acc = acc / cnt;
      return acc;
   endfunction

   function automatic void close_frame();
      in_row = 0; in_col = 0; emit_row = 0; emit_col = 0;
      frame_open = 0;
   endfunction

   // advance the predictor by one accepted word
   function automatic void filter_step(logic [1:0] op, logic [39:0] d);
      int unsigned R, C, hr, hc, trow, tcol, n;
      bit done;
      filtered_pixel_type fp;
      R = frame_rows(); C = frame_cols();
      hr = half_size(win_rows_cfg); hc = half_size(win_cols_cfg);
      n = 0; done = 0;
      if (op == fwsm_pkg::OP_WEIGHT) begin
         if (d[2:0] < fwsm_pkg::MAX_WINDOW && d[5:3] < fwsm_pkg::MAX_WINDOW)
            weights[d[2:0]*fwsm_pkg::MAX_WINDOW + d[5:3]] = shortint'(d[21:6]);
         return;
      end
      if (op == fwsm_pkg::OP_NONE) return;
      if (op == fwsm_pkg::OP_FLUSH && !frame_open) return;
      if (in_row < R && in_col < C)
         pixel_lines[(in_row % fwsm_pkg::LINES)*fwsm_pkg::MAX_LINE + in_col] =
            (op == fwsm_pkg::OP_PIXEL) ? shortint'(d[37:22]) : 16'sd0;
      frame_open = 1;
      while (n < fwsm_pkg::BURST) begin
         trow = emit_row + hr;
         tcol = (emit_col + hc > C - 1) ? C - 1 : emit_col + hc;
         if (trow > in_row || (trow == in_row && tcol > in_col)) break;
         fp.value = 40'(window_sum(emit_row, emit_col));
         fp.row = 16'(emit_row);
         fp.col = 11'(emit_col);
         fp.last = 0;
         fp.done = (emit_row == R - 1 && emit_col == C - 1);
         filtered_q = {filtered_q, fp};
         n++;
         if (fp.done) begin
            done = 1;
            break;
         end
         emit_col++;
         if (emit_col >= C) begin
            emit_col = 0;
            emit_row++;
         end
      end
      if (done) begin
         close_frame();
         frames_done++;
      end else begin
         in_col++;
         if (in_col >= C) begin
            in_col = 0;
            in_row++;
         end
      end
      if (n > 0) filtered_q[$].last = 1;
   endfunction

   // result checker
   always @(posedge clock) begin
      filtered_pixel_type fp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked++;
         if (filtered_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: data %h last %b done %b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            fp = filtered_q.pop_front();
            if (rsp_tdata[39:0] !== fp.value || rsp_tdata[55:40] !== fp.row ||
                rsp_tdata[66:56] !== fp.col || rsp_tlast !== fp.last ||
                rsp_tuser[0] !== fp.done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp val %h row %0d col %0d last %b done %b,",
                            " got val %h row %0d col %0d last %b done %b"},
                           fp.value, fp.row, fp.col, fp.last, fp.done,
                           rsp_tdata[39:0], rsp_tdata[55:40], rsp_tdata[66:56],
                           rsp_tlast, rsp_tuser[0]);
            end
         end
      end
   end

   // result back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("[focal_weighted_sum_mean_filter] ERROR");
         $finish;
      end
   end

   // send one input word and update the predictor on acceptance
   task automatic send_word(logic [1:0] op, logic [39:0] d);
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == fwsm_pkg::OP_PIXEL) pixels_sent++;
      filter_step(op, d);
   endtask

   function automatic logic [39:0] weight_word(int r, int c, logic [15:0] w);
      return {18'd0, w, 3'(c), 3'(r)};
   endfunction

   function automatic logic [39:0] pixel_word(logic [15:0] p);
      return {2'd0, p, 22'(($urandom() & 32'h3fffff))};
   endfunction

   // random pixel, leaning on the extremes now and then
   function automatic logic [15:0] some_pixel();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return 16'($urandom());
      endcase
   endfunction

   // let the block finish, then rewrite every register
   task automatic write_regs(int wr, int wc, int rr, int rc, int mean);
      int vals [5];
      vals = '{wr, wc, rr, rc, mean};
      req_tvalid <= 1'b0;
      wait (filtered_q.size() == 0);
      repeat (600) @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_data  <= 16'(vals[i]);
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      win_rows_cfg = vals[0] & 7;
      win_cols_cfg = vals[1] & 7;
      rast_rows_cfg = vals[2] & 16'hffff;
      rast_cols_cfg = vals[3] & 12'hfff;
      mean_cfg = vals[4] & 1;
      close_frame();
   endtask

   // pixels for the whole frame, then drain with flushes or late pixels
   task automatic run_frame();
      int npix;
      npix = frame_rows() * frame_cols();
      for (int k = 0; k < npix; k++)
         send_word(fwsm_pkg::OP_PIXEL, pixel_word(some_pixel()));
      while (frame_open) begin
         if ($urandom_range(3) == 0) send_word(fwsm_pkg::OP_PIXEL, pixel_word(some_pixel()));
         else send_word(fwsm_pkg::OP_FLUSH, 40'($urandom()));
      end
   endtask

   task automatic test_weight_loads();
      for (int r = 0; r < fwsm_pkg::MAX_WINDOW; r++)
         for (int c = 0; c < fwsm_pkg::MAX_WINDOW; c++)
            send_word(fwsm_pkg::OP_WEIGHT, weight_word(r, c,
               (r == 0 && c == 0) ? 16'h8000 : (r == 6 && c == 6) ? 16'h7fff
                                  : 16'($urandom())));
      // out-of-range addresses, no-op opcode, flush with no frame open
      send_word(fwsm_pkg::OP_WEIGHT, weight_word(7, 2, 16'h1234));
      send_word(fwsm_pkg::OP_WEIGHT, weight_word(3, 7, 16'hffff));
      send_word(fwsm_pkg::OP_NONE, 40'hff_ffff_ffff);
      send_word(fwsm_pkg::OP_FLUSH, 40'($urandom()));
   endtask

   task automatic test_small_frames();
      write_regs(3, 3, 3, 3, 0);
      run_frame();
      write_regs(3, 3, 2, 3, 1);
      run_frame();
   endtask

   task automatic test_size_extremes();
      // full window, mean, on a single pixel frame from zero sizes
      write_regs(7, 7, 0, 0, 1);
      run_frame();
      // even and zero window sizes
      write_regs(6, 0, 3, 2, 0);
      run_frame();
      write_regs(4, 2, 2, 3, 1);
      run_frame();
      // largest frame, aborted after a few pixels by the next write
      write_regs(7, 7, 65535, 4095, 0);
      for (int k = 0; k < 3; k++) send_word(fwsm_pkg::OP_PIXEL, pixel_word(some_pixel()));
      write_regs(1, 7, 1, 2048, 0);
      for (int k = 0; k < 5; k++) send_word(fwsm_pkg::OP_PIXEL, pixel_word(some_pixel()));
      // abort a frame that already released results
      write_regs(1, 1, 4, 4, 0);
      for (int k = 0; k < 3; k++) send_word(fwsm_pkg::OP_PIXEL, pixel_word(some_pixel()));
   endtask

   task automatic test_random_frames();
      int start, npix, r;
      start = pixels_sent;
      while (pixels_sent - start < 24) begin
         r = pixels_sent - start;
         if (r < 8) begin
            send_gap_pct = 32; stall_pct = 47;
         end else if (r < 16) begin
            send_gap_pct = 47; stall_pct = 32;
         end else begin
            send_gap_pct = 0; stall_pct = 0;
         end
         write_regs($urandom_range(7), $urandom_range(7), $urandom_range(1, 3),
                    $urandom_range(1, 4), $urandom_range(1));
         npix = frame_rows() * frame_cols();
         for (int k = 0; k < npix; k++) begin
            // a little noise between pixels
            case ($urandom_range(19))
               0: send_word(fwsm_pkg::OP_WEIGHT,
                            weight_word($urandom_range(7), $urandom_range(7),
                                        16'($urandom())));
               1: send_word(fwsm_pkg::OP_NONE, 40'($urandom()));
               default: ;
            endcase
            send_word(fwsm_pkg::OP_PIXEL, pixel_word(some_pixel()));
         end
         while (frame_open) begin
            if ($urandom_range(3) == 0)
               send_word(fwsm_pkg::OP_PIXEL, pixel_word(some_pixel()));
            else
               send_word(fwsm_pkg::OP_FLUSH, 40'($urandom()));
         end
      end
   endtask

   initial begin
      win_rows_cfg = 3; win_cols_cfg = 3; rast_rows_cfg = 1; rast_cols_cfg = 1;
      mean_cfg = 0;
      close_frame();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_weight_loads();
      test_small_frames();
      test_size_extremes();
      test_random_frames();
      req_tvalid <= 1'b0;
      wait (filtered_q.size() == 0);
      repeat (600) @(posedge clock);
      $display("ran %0d pixel words over %0d completed frames, checked %0d results",
               pixels_sent, frames_done, checked);
      $display("covered weight loads, ignored words, size extremes and random frames");
      if (mismatches == 0 && filtered_q.size() == 0)
         $display("[focal_weighted_sum_mean_filter] OK");
      else
         $display("[focal_weighted_sum_mean_filter] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/fwsm_pkg.sv
rtl/core/fwsm_ram.sv
rtl/core/fwsm_cell.sv
rtl/core/fwsm_div.sv
rtl/core/focal_weighted_sum_mean_filter.sv
verif/testbench.sv
